[sv/fgn_pkg.sv]
// Shared constants and helpers for the fractal gradient noise block.
// No dependencies; used by fgn_grad_mem and fractal_gradient_noise.
`default_nettype none
package fgn_pkg;

    localparam int MAX_SIDE    = 256;
    localparam int FIRST_CELL  = 8;
    localparam int MAX_OCTAVES = 5;

    localparam int LAT_DIM    = MAX_SIDE / FIRST_CELL + 2;
    localparam int STORE_SIZE = MAX_OCTAVES * LAT_DIM * LAT_DIM;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int FC_SH      = $clog2(FIRST_CELL);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_EVAL  = 1'b1;

    localparam logic       REG_SIDE_X = 1'b0;
    localparam logic       REG_SIDE_Y = 1'b1;

    // per-octave sequencer steps
    localparam logic [4:0] STEP_WEIGHT = 5'd8;
    localparam logic [4:0] STEP_CORNER = 5'd12;
    localparam logic [4:0] STEP_FINISH = 5'd28;

    localparam logic signed [29:0] H_MAX = 30'sd33554431;
    localparam logic signed [29:0] H_MIN = -30'sd33554432;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [31:0]       wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [2:0] k,
                                                     input logic [5:0] i,
                                                     input logic [5:0] j);
        logic [31:0] a;
        a = 32'(k) * 32'(LAT_DIM * LAT_DIM) + 32'(i) * 32'(LAT_DIM) + 32'(j);
        return a[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

[sv/fgn_grad_mem.sv]
// Gradient store: one 32-bit entry per octave and lattice corner.
// Depends on fgn_pkg for depth and the request struct.
`default_nettype none
module fgn_grad_mem (
    input  wire logic              clk,
    input  wire fgn_pkg::mem_req_t req,
    output logic [31:0]            rd_data
);

    logic [31:0] mem [fgn_pkg::STORE_SIZE];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule
`default_nettype wire

[sv/fractal_gradient_noise.sv]
// Top level of the fractal gradient noise block: stream ports, sequencer, shared multiplier.
// Depends on fgn_pkg and fgn_grad_mem.
//
// A gradient write (tuser 0) gives no result. An evaluate (tuser 1) walks
// the octaves one at a time through a single shared 35x18 multiplier: per
// octave it forms the smoothstep terms, the four corner weights, then for
// each corner the gradient read and dot products, and last scales and rounds
// the octave sum. After up to five octaves the result is handed over once the
// output register is free. A pixel outside the sides, or one with no octave to
// add, skips the octave walk. The input is not ready while an evaluate is in
// progress. Lattice entries must be written before they are read; there is no
// clearing of the store after reset.
`default_nettype none
module fractal_gradient_noise (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // octave[2:0] lattice_i[8:3] lattice_j[14:9] grad_x[30:15] grad_y[46:31]
    // pixel_x[54:47] pixel_y[62:55], bit 63 zero
    input  wire logic [63:0] s_tdata,
    // opcode[0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // height[25:0], bits 31:26 zero
    output logic [31:0]      m_tdata,
    // outside[0]
    output logic             m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data
);

    logic [1:0]  state_reg, state_next;
    logic [4:0]  step_reg, step_next;
    logic [2:0]  oct_reg, oct_next;
    logic [8:0]  side_x_reg, side_y_reg;
    logic        out_valid_reg, out_valid_next;

    logic [7:0]  px_reg, px_next, py_reg, py_next;
    logic [9:0]  sxc_reg, sxc_next, syc_reg, syc_next;
    logic        flag_reg, flag_next;
    logic [31:0] sq_reg, sq_next;
    logic [16:0] smo_reg [4];
    logic [16:0] smo_next [4];
    logic [16:0] wt_reg [4];
    logic [16:0] wt_next [4];
    logic signed [33:0] dot_reg, dot_next;
    logic signed [52:0] blend_reg, blend_next;
    logic signed [29:0] sum_reg, sum_next;
    logic [25:0] out_h_reg, out_h_next;
    logic        out_o_reg, out_o_next;

    fgn_pkg::mem_req_t req;
    logic [31:0] rd_data;

    fgn_grad_mem u_mem (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    // input fields
    logic [2:0]  in_oct;
    logic [5:0]  in_li, in_lj;
    logic [7:0]  in_px, in_py;
    assign in_oct = s_tdata[2:0];
    assign in_li  = s_tdata[8:3];
    assign in_lj  = s_tdata[14:9];
    assign in_px  = s_tdata[54:47];
    assign in_py  = s_tdata[62:55];

    logic [9:0]  sx_clamp, sy_clamp;
    assign sx_clamp = (10'(side_x_reg) > 10'(fgn_pkg::MAX_SIDE)) ?
                      10'(fgn_pkg::MAX_SIDE) : 10'(side_x_reg);
    assign sy_clamp = (10'(side_y_reg) > 10'(fgn_pkg::MAX_SIDE)) ?
                      10'(fgn_pkg::MAX_SIDE) : 10'(side_y_reg);

    logic        accept;
    assign s_tready = (state_reg == fgn_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // write range check: lattice count per octave is MAX_SIDE / cell + 2
    logic [11:0] lat_n;
    logic        wr_ok;
    assign lat_n = 12'((fgn_pkg::MAX_SIDE >> (fgn_pkg::FC_SH + int'(in_oct))) + 2);
    assign wr_ok = (32'(in_oct) < 32'(fgn_pkg::MAX_OCTAVES)) &&
                   (12'(in_li) < lat_n) && (12'(in_lj) < lat_n) &&
                   (32'(in_li) < 32'(fgn_pkg::LAT_DIM)) &&
                   (32'(in_lj) < 32'(fgn_pkg::LAT_DIM));

    // per-octave geometry
    logic [3:0]  sh;
    logic [20:0] px_shl, py_shl;
    logic [15:0] dx, dy;
    logic [7:0]  i0w, j0w;
    assign sh     = 4'(fgn_pkg::FC_SH) + 4'(oct_reg);
    assign px_shl = 21'(px_reg) << (5'd16 - 5'(sh));
    assign py_shl = 21'(py_reg) << (5'd16 - 5'(sh));
    assign dx     = px_shl[15:0];
    assign dy     = py_shl[15:0];
    assign i0w    = px_reg >> sh;
    assign j0w    = py_reg >> sh;

    logic [4:0]  cs;
    logic [1:0]  corner, sub, m_idx;
    assign cs     = step_reg - fgn_pkg::STEP_CORNER;
    assign corner = (step_reg >= fgn_pkg::STEP_CORNER) ? cs[3:2] : step_reg[1:0];
    assign sub    = cs[1:0];
    assign m_idx  = step_reg[2:1];

    logic [16:0] t17;
    always_comb
    begin
        case (m_idx)
            2'd0:    t17 = 17'h10000 - 17'(dx);
            2'd1:    t17 = 17'(dx);
            2'd2:    t17 = 17'h10000 - 17'(dy);
            default: t17 = 17'(dy);
        endcase
    end

    logic signed [17:0] ddx, ddy;
    assign ddx = corner[0] ? (18'sd0 + $signed(18'(dx)) - 18'sd65536) : $signed(18'(dx));
    assign ddy = corner[1] ? (18'sd0 + $signed(18'(dy)) - 18'sd65536) : $signed(18'(dy));

    logic [5:0]  li, lj;
    assign li = i0w[5:0] + 6'(corner[0]);
    assign lj = j0w[5:0] + 6'(corner[1]);

    // shared multiplier
    logic signed [34:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [52:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [51:0] ss_v;
    logic [52:0] w_round;
    assign ss_v = ((52'(sq_reg) << 16) * 52'd3) - (52'($unsigned(mul_p[47:0])) << 1)
                  + 52'h80000000;
    assign w_round = $unsigned(mul_p) + 53'd32768;

    // octave scaling and rounding, ties away from zero
    logic signed [63:0] bv;
    logic [63:0] mag;
    logic [63:0] q64;
    logic [29:0] q;
    assign bv  = 64'(blend_reg) <<< sh;
    assign mag = bv[63] ? $unsigned(-bv) : $unsigned(bv);
    assign q64 = (mag + 64'h40000000) >> 31;
    assign q   = q64[29:0];

    logic [3:0]  k_nxt;
    logic [11:0] cell_nxt, cell0;
    logic        more;
    assign k_nxt    = 4'(oct_reg) + 4'd1;
    assign cell_nxt = 12'(fgn_pkg::FIRST_CELL) << k_nxt;
    assign cell0    = 12'(fgn_pkg::FIRST_CELL);
    assign more     = (32'(k_nxt) < 32'(fgn_pkg::MAX_OCTAVES)) &&
                      (cell_nxt < 12'(sxc_reg)) && (cell_nxt < 12'(syc_reg));

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        oct_next       = oct_reg;
        out_valid_next = out_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        sxc_next       = sxc_reg;
        syc_next       = syc_reg;
        flag_next      = flag_reg;
        sq_next        = sq_reg;
        smo_next       = smo_reg;
        wt_next        = wt_reg;
        dot_next       = dot_reg;
        blend_next     = blend_reg;
        sum_next       = sum_reg;
        out_h_next     = out_h_reg;
        out_o_next     = out_o_reg;
        mul_a          = '0;
        mul_b          = '0;
        req.wr_en      = 1'b0;
        req.wr_addr    = fgn_pkg::store_addr(in_oct, in_li, in_lj);
        req.wr_data    = s_tdata[46:15];
        req.rd_en      = 1'b0;
        req.rd_addr    = fgn_pkg::store_addr(oct_reg, li, lj);

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            fgn_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == fgn_pkg::OP_WRITE)
                    begin
                        req.wr_en = wr_ok;
                    end
                    else
                    begin
                        px_next    = in_px;
                        py_next    = in_py;
                        sxc_next   = sx_clamp;
                        syc_next   = sy_clamp;
                        oct_next   = '0;
                        step_next  = '0;
                        blend_next = '0;
                        sum_next   = '0;
                        flag_next  = (10'(in_px) >= sx_clamp) || (10'(in_py) >= sy_clamp);
                        if (flag_next || !(cell0 < 12'(sx_clamp)) ||
                            !(cell0 < 12'(sy_clamp)))
                        begin
                            state_next = fgn_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = fgn_pkg::ST_RUN;
                        end
                    end
                end
            end
            fgn_pkg::ST_RUN:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg < fgn_pkg::STEP_WEIGHT)
                begin
                    mul_b = $signed(18'(t17[15:0]));
                    if (!step_reg[0])
                    begin
                        mul_a   = $signed(35'(t17[15:0]));
                        sq_next = $unsigned(mul_p[31:0]);
                    end
                    else
                    begin
                        mul_a = $signed(35'(sq_reg));
                        smo_next[m_idx] = t17[16] ? 17'h10000 : ss_v[48:32];
                    end
                end
                else if (step_reg < fgn_pkg::STEP_CORNER)
                begin
                    mul_a = $signed(35'(smo_reg[{1'b0, corner[0]}]));
                    mul_b = $signed(18'(smo_reg[{1'b1, corner[1]}]));
                    wt_next[corner] = w_round[32:16];
                end
                else if (step_reg < fgn_pkg::STEP_FINISH)
                begin
                    case (sub)
                        2'd0:
                        begin
                            req.rd_en = 1'b1;
                        end
                        2'd1:
                        begin
                            mul_a    = 35'($signed(rd_data[15:0]));
                            mul_b    = ddx;
                            dot_next = mul_p[33:0];
                        end
                        2'd2:
                        begin
                            mul_a    = 35'($signed(rd_data[31:16]));
                            mul_b    = ddy;
                            dot_next = dot_reg + mul_p[33:0];
                        end
                        default:
                        begin
                            mul_a      = 35'(dot_reg);
                            mul_b      = $signed(18'(wt_reg[corner]));
                            blend_next = blend_reg + mul_p;
                        end
                    endcase
                end
                else
                begin
                    sum_next   = bv[63] ? (sum_reg - $signed(q)) : (sum_reg + $signed(q));
                    blend_next = '0;
                    step_next  = '0;
                    if (more)
                    begin
                        oct_next = k_nxt[2:0];
                    end
                    else
                    begin
                        state_next = fgn_pkg::ST_DONE;
                    end
                end
            end
            fgn_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_o_next     = flag_reg;
                    if (flag_reg)
                    begin
                        out_h_next = '0;
                    end
                    else if (sum_reg > fgn_pkg::H_MAX)
                    begin
                        out_h_next = fgn_pkg::H_MAX[25:0];
                    end
                    else if (sum_reg < fgn_pkg::H_MIN)
                    begin
                        out_h_next = fgn_pkg::H_MIN[25:0];
                    end
                    else
                    begin
                        out_h_next = sum_reg[25:0];
                    end
                    state_next = fgn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fgn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fgn_pkg::ST_IDLE;
            step_reg      <= '0;
            oct_reg       <= '0;
            out_valid_reg <= 1'b0;
            side_x_reg    <= 9'd256;
            side_y_reg    <= 9'd256;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            oct_reg       <= oct_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fgn_pkg::REG_SIDE_X)
                begin
                    side_x_reg <= cfg_data;
                end
                else
                begin
                    side_y_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        sxc_reg   <= sxc_next;
        syc_reg   <= syc_next;
        flag_reg  <= flag_next;
        sq_reg    <= sq_next;
        smo_reg   <= smo_next;
        wt_reg    <= wt_next;
        dot_reg   <= dot_next;
        blend_reg <= blend_next;
        sum_reg   <= sum_next;
        out_h_reg <= out_h_next;
        out_o_reg <= out_o_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_h_reg};
    assign m_tuser  = out_o_reg;

endmodule
`default_nettype wire

[test/tb_fractal_gradient_noise.sv]
// Self-checking testbench for fractal_gradient_noise: gradient writes and pixel
// evaluates on the stream ports, side registers on the cfg channel.
// Depends on fgn_pkg and the block's RTL; predicts every height internally.
`timescale 1ns / 1ps
module tb_fractal_gradient_noise;

    typedef struct {
        logic        op;
        logic [2:0]  oct;
        logic [5:0]  li;
        logic [5:0]  lj;
        logic [15:0] gx;
        logic [15:0] gy;
        logic [7:0]  px;
        logic [7:0]  py;
    } noise_item_t;

    typedef struct {
        logic [25:0] height;
        logic        outside;
    } height_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = fgn_pkg::REG_SIDE_X;
    logic [8:0]  cfg_data = '0;

    fractal_gradient_noise i_dut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [31:0] grad_mem [0:fgn_pkg::STORE_SIZE-1];
    int unsigned side_x_q = 256, side_y_q = 256;
    // stimulus-side bookkeeping of lattice entries that will have been written
    bit          gen_written [0:fgn_pkg::STORE_SIZE-1];
    int unsigned gen_sx = 256, gen_sy = 256;

    noise_item_t pending_items[$];
    height_t     expected_heights[$];
    noise_item_t cur_item;
    bit          taken = 1'b0;
    int          gap_left = 0, burst_left = 0;
    int          errors = 0, n_writes = 0, n_evals = 0, n_outside = 0, n_results = 0;
    int          stall_pat = 16'hFFFF, stall_pos = 0;
    longint      cycles = 0;
    localparam longint CYCLE_LIMIT = 3_000_000;

    function automatic int unsigned lat_index(int unsigned k, int unsigned i, int unsigned j);
        return (k * fgn_pkg::LAT_DIM + i) * fgn_pkg::LAT_DIM + j;
    endfunction

    function automatic longint smoothstep_q16(longint t);
        longint unsigned u, v;
        u = t;
        v = 3 * u * u * 65536 - 2 * u * u * u;
        return longint'((v + 64'h8000_0000) >> 32);
    endfunction

    function automatic longint round_q31(longint v);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        m = (m + (64'd1 << 30)) >> 31;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint octave_height(int unsigned k, int unsigned s,
                                             int unsigned px, int unsigned py);
        longint dx, dy, blend, ddx, ddy, wx, wy, w, gxs, gys;
        int unsigned ci, cj;
        logic [31:0] e;
        dx = ((px % s) * 65536) / s;
        dy = ((py % s) * 65536) / s;
        blend = 0;
        for (int c = 0; c < 4; c++)
        begin
            ci = c & 1;
            cj = c >> 1;
            e = grad_mem[lat_index(k, px / s + ci, py / s + cj)];
            gxs = longint'($signed(e[15:0]));
            gys = longint'($signed(e[31:16]));
            ddx = ci ? dx - 65536 : dx;
            ddy = cj ? dy - 65536 : dy;
            wx = ci ? smoothstep_q16(dx) : smoothstep_q16(65536 - dx);
            wy = cj ? smoothstep_q16(dy) : smoothstep_q16(65536 - dy);
            w = (wx * wy + 32768) >>> 16;
            blend += (gxs * ddx + gys * ddy) * w;
        end
        return round_q31(blend * s);
    endfunction

    // apply one accepted item; returns 1 when a result is due
    function automatic bit predict_height(noise_item_t it, output height_t r);
        int unsigned sx, sy, n, s;
        longint sum;
        r.height = '0;
        r.outside = 1'b0;
        if (it.op == fgn_pkg::OP_WRITE)
        begin
            if (it.oct >= fgn_pkg::MAX_OCTAVES)
                return 0;
            n = fgn_pkg::MAX_SIDE / (fgn_pkg::FIRST_CELL << it.oct) + 2;
            if (it.li >= n || it.lj >= n)
                return 0;
            grad_mem[lat_index(it.oct, it.li, it.lj)] = {it.gy, it.gx};
            return 0;
        end
        sx = (side_x_q > fgn_pkg::MAX_SIDE) ? fgn_pkg::MAX_SIDE : side_x_q;
        sy = (side_y_q > fgn_pkg::MAX_SIDE) ? fgn_pkg::MAX_SIDE : side_y_q;
        if (it.px >= sx || it.py >= sy)
        begin
            r.outside = 1'b1;
            return 1;
        end
        sum = 0;
        s = fgn_pkg::FIRST_CELL;
        for (int k = 0; k < fgn_pkg::MAX_OCTAVES && s < sx && s < sy; k++)
        begin
            sum += octave_height(k, s, it.px, it.py);
            s = s << 1;
        end
        if (sum > fgn_pkg::H_MAX)
            sum = fgn_pkg::H_MAX;
        if (sum < fgn_pkg::H_MIN)
            sum = fgn_pkg::H_MIN;
        r.height = sum[25:0];
        return 1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic logic [15:0] rand_grad();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_write(int unsigned k, int unsigned i, int unsigned j,
                              logic [15:0] gx, logic [15:0] gy);
        noise_item_t it;
        it.op = fgn_pkg::OP_WRITE;
        it.oct = k;
        it.li = i;
        it.lj = j;
        it.gx = gx;
        it.gy = gy;
        it.px = 8'($urandom);
        it.py = 8'($urandom);
        pending_items.push_back(it);
        if (k < fgn_pkg::MAX_OCTAVES
            && i < fgn_pkg::MAX_SIDE / (fgn_pkg::FIRST_CELL << k) + 2
            && j < fgn_pkg::MAX_SIDE / (fgn_pkg::FIRST_CELL << k) + 2)
            gen_written[lat_index(k, i, j)] = 1'b1;
    endtask

    // evaluate, preceded by writes of any corner it would read unwritten
    task automatic push_eval(int unsigned px, int unsigned py);
        noise_item_t it;
        int unsigned sx, sy, s, ix;
        sx = (gen_sx > fgn_pkg::MAX_SIDE) ? fgn_pkg::MAX_SIDE : gen_sx;
        sy = (gen_sy > fgn_pkg::MAX_SIDE) ? fgn_pkg::MAX_SIDE : gen_sy;
        if (px < sx && py < sy)
        begin
            s = fgn_pkg::FIRST_CELL;
            for (int k = 0; k < fgn_pkg::MAX_OCTAVES && s < sx && s < sy; k++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    ix = lat_index(k, px / s + (c & 1), py / s + (c >> 1));
                    if (!gen_written[ix])
                        push_write(k, px / s + (c & 1), py / s + (c >> 1),
                                   rand_grad(), rand_grad());
                end
                s = s << 1;
            end
        end
        it.op = fgn_pkg::OP_EVAL;
        it.oct = 3'($urandom);
        it.li = 6'($urandom);
        it.lj = 6'($urandom);
        it.gx = 16'($urandom);
        it.gy = 16'($urandom);
        it.px = px;
        it.py = py;
        pending_items.push_back(it);
    endtask

    task automatic push_random(int count);
        int unsigned k, n, lim_x, lim_y;
        for (int t = 0; t < count; t++)
        begin
            lim_x = (gen_sx > fgn_pkg::MAX_SIDE) ? fgn_pkg::MAX_SIDE : gen_sx;
            lim_y = (gen_sy > fgn_pkg::MAX_SIDE) ? fgn_pkg::MAX_SIDE : gen_sy;
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    k = $urandom_range(0, fgn_pkg::MAX_OCTAVES - 1);
                    n = fgn_pkg::MAX_SIDE / (fgn_pkg::FIRST_CELL << k) + 2;
                    push_write(k, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                               rand_grad(), rand_grad());
                end
                3:
                begin
                    // ignored write: bad octave or lattice index past the grid
                    k = $urandom_range(0, 7);
                    if (k < fgn_pkg::MAX_OCTAVES)
                    begin
                        n = fgn_pkg::MAX_SIDE / (fgn_pkg::FIRST_CELL << k) + 2;
                        push_write(k, $urandom_range(n, 63), $urandom_range(0, 63),
                                   rand_grad(), rand_grad());
                    end
                    else
                        push_write(k, $urandom_range(0, 63), $urandom_range(0, 63),
                                   rand_grad(), rand_grad());
                end
                4: push_eval($urandom_range(0, 255), $urandom_range(0, 255));
                default:
                begin
                    if (lim_x == 0 || lim_y == 0)
                        push_eval($urandom_range(0, 255), $urandom_range(0, 255));
                    else
                        push_eval($urandom_range(0, lim_x - 1), $urandom_range(0, lim_y - 1));
                end
            endcase
        end
    endtask

    task automatic write_side(logic idx, int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[8:0];
        do @(posedge clk); while (!cfg_ready);
        if (idx == fgn_pkg::REG_SIDE_X)
            side_x_q = value;
        else
            side_y_q = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !s_tvalid && expected_heights.size() == 0);
        // a trailing write gives no result but may still be in progress
        repeat (200) @(posedge clk);
    endtask

    // sender: bursts with gaps, items taken from the pending queue
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || taken))
        begin
            taken = 1'b0;
            if (gap_left > 0 || pending_items.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                s_tvalid <= 1'b0;
            end
            else
            begin
                cur_item = pending_items.pop_front();
                s_tdata  <= {1'b0, cur_item.py, cur_item.px, cur_item.gy, cur_item.gx,
                             cur_item.lj, cur_item.li, cur_item.oct};
                s_tuser  <= cur_item.op;
                s_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // receiver stall pattern, reshuffled each time its position wraps
    always @(negedge clk)
    begin
        if (stall_pos == 0)
            case ($urandom_range(0, 3))
                0: stall_pat = 16'hFFFF;
                1: stall_pat = 16'h0001;
                default: stall_pat = $urandom | 16'h0100;
            endcase
        m_tready <= rst_n && stall_pat[stall_pos];
        stall_pos = (stall_pos + 1) % 16;
    end

    always @(posedge clk)
    begin
        height_t r, want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
        if (rst_n && s_tvalid && s_tready && !taken)
        begin
            taken = 1'b1;
            if (cur_item.op == fgn_pkg::OP_WRITE)
                n_writes++;
            else
                n_evals++;
            if (predict_height(cur_item, r))
                expected_heights.push_back(r);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (m_tuser)
                n_outside++;
            if (expected_heights.size() == 0)
            begin
                report_mismatch("unexpected result height", $signed(m_tdata[25:0]), 0);
            end
            else
            begin
                want = expected_heights.pop_front();
                if (m_tdata[25:0] !== want.height)
                    report_mismatch("height", $signed(m_tdata[25:0]), $signed(want.height));
                if (m_tdata[31:26] !== 6'd0)
                    report_mismatch("tdata pad", m_tdata[31:26], 0);
                if (m_tuser !== want.outside)
                    report_mismatch("outside", m_tuser, want.outside);
            end
        end
    end

    initial
    begin
        int unsigned sides_x [6] = '{256, 1, 100, 0, 511, 9};
        int unsigned sides_y [6] = '{256, 256, 37, 5, 511, 200};
        for (int i = 0; i < fgn_pkg::STORE_SIZE; i++)
        begin
            grad_mem[i] = '0;
            gen_written[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extreme gradients, corner pixels, ignored writes
        push_write(0, 0, 0, 16'h8000, 16'h8000);
        push_write(0, 1, 0, 16'h7FFF, 16'h8000);
        push_write(0, 0, 1, 16'h8000, 16'h7FFF);
        push_write(0, 1, 1, 16'h7FFF, 16'h7FFF);
        push_write(7, 63, 63, 16'hFFFF, 16'hFFFF);
        push_write(4, 4, 0, 16'h1234, 16'h5678);
        push_write(0, 34, 2, 16'h1111, 16'h2222);
        push_write(0, 33, 33, 16'h7FFF, 16'h8000);
        push_eval(0, 0);
        push_eval(7, 7);
        push_eval(8, 8);
        push_eval(255, 255);
        push_eval(127, 128);
        push_eval(255, 0);
        push_eval(0, 255);
        // every fresh evaluate also queues the writes of its unwritten corners
        push_random(64);
        drain();

        for (int p = 1; p < 6; p++)
        begin
            write_side(fgn_pkg::REG_SIDE_X, sides_x[p]);
            write_side(fgn_pkg::REG_SIDE_Y, sides_y[p]);
            gen_sx = sides_x[p];
            gen_sy = sides_y[p];
            push_eval(0, 0);
            push_eval(255, 255);
            push_random(42);
            drain();
        end

        $display("%0d gradient writes and %0d evaluates accepted over 6 side settings;",
                 n_writes, n_evals);
        $display("%0d results checked, %0d of them outside the sides", n_results, n_outside);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
